@@ design/pbct_pkg.sv @@
`timescale 1ns / 1ps

package pbct_pkg;

    localparam int ROWS_PER_BAND  = 7;
    localparam int WORD_BITS      = 8 * ROWS_PER_BAND;
    localparam int EXPAND_COLUMNS = 128;
    localparam int INIT_LEN       = 5;
    localparam int HEADER_LEN     = 5;
    localparam int FINAL_LEN      = 2;

    localparam int WIDTH_RESET  = 600;
    localparam int HEIGHT_RESET = 1792;

    // ceil(h / 7) == ((h + 6) * BANDS_RECIP) >> RECIP_SHIFT for all 11-bit heights
    localparam int BANDS_RECIP = 9363;
    localparam int RECIP_SHIFT = 16;

    localparam int CFG_DATA_BITS = 11;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_FETCH   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [2:0] PH_INIT    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_COLUMNS = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_NEWLINE = 3'd4;
    localparam logic [2:0] PH_FINAL   = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [7:0] CHR_ESC   = 8'h1B;
    localparam logic [7:0] CHR_AT    = 8'h40;
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_SEVEN = 8'h07;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] GFX_MODE  = 8'h05;
    localparam logic [7:0] CHR_NL    = 8'h0A;

    typedef struct packed {
        logic       band_done;
        logic       band_current;
        logic       col_done;
        logic [2:0] row;
    } t_mask_ctl;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CHR_ESC;
            3'd1:    b = CHR_AT;
            3'd2:    b = CHR_ESC;
            3'd3:    b = CHR_A;
            default: b = CHR_SEVEN;
        endcase
        return b;
    endfunction

endpackage

@@ design/printer_band_column_transpose.sv @@
`timescale 1ns / 1ps
// Raster-to-dot-matrix band transposer. Raster bytes go in row-major (cmd load), seven rows
// make a band, and every column byte of a band lives in one 56-bit word of an on-chip
// store of MAX_BANDS * MAX_WIDTH_BYTES words. Each fetch returns the next byte of the printer
// stream: init sequence, bands from the last configured to the first (header, column bytes,
// optional 128 zero columns, newline), then the closing pair; fetches after the end flag
// no_data. A fetch is accepted, steps across any phase boundaries it meets, reads the store
// and masks the word for a column byte, then hands its byte to the output register once
// that is free. The store has no clearing pass; pixels past the load position read as zero
// from the position counters.
module printer_band_column_transpose #(
    parameter int MAX_BANDS       = 256,
    parameter int MAX_WIDTH_BYTES = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [0:0]                         i_cfg_index,
    input  logic [pbct_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [7:0]                         i_raster_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_last_byte,
    output logic                               o_no_data
);
    import pbct_pkg::*;

    localparam int DEPTH = MAX_BANDS * MAX_WIDTH_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BANDS + 1);
    localparam int YW    = $clog2(MAX_WIDTH_BYTES + 1);
    localparam int CW    = $clog2(MAX_WIDTH_BYTES);
    localparam int IW    = (YW + 3 > 8) ? YW + 3 : 8;

    localparam int RAW_BYTES   = (WIDTH_RESET + 7) / 8;
    localparam int RAW_BANDS   = (HEIGHT_RESET + 6) / ROWS_PER_BAND;
    localparam int RESET_BYTES = (RAW_BYTES > MAX_WIDTH_BYTES) ? MAX_WIDTH_BYTES : RAW_BYTES;
    localparam int RESET_BANDS = (RAW_BANDS > MAX_BANDS) ? MAX_BANDS : RAW_BANDS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_MASK = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    logic [1:0]           r_state;
    logic [YW-1:0]        r_width_bytes;
    logic [BW-1:0]        r_bands;
    logic [BW-1:0]        r_load_band;
    logic [2:0]           r_load_row;
    logic [CW-1:0]        r_load_col;
    logic [2:0]           r_phase;
    logic [BW-1:0]        r_band;
    logic [IW-1:0]        r_index;
    logic [7:0]           r_res_byte;
    logic                 r_res_last;
    logic                 r_res_nodata;
    logic [BW-1:0]        r_rd_band;
    logic [CW-1:0]        r_rd_col;
    logic [2:0]           r_rd_bit;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;
    logic                 r_out_nodata;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [YW-1:0] n_width_bytes;
    logic [BW-1:0] n_bands;
    logic [2:0]    n_phase;
    logic [BW-1:0] n_band;
    logic [IW-1:0] n_index;
    logic [7:0]    n_res_byte;
    logic          n_res_last;
    logic          n_res_nodata;
    logic          step_emit;
    logic          step_read;

    logic [10:0] cfg_w_sum;
    logic [7:0]  cfg_bytes_raw;
    logic [11:0] cfg_h_sum;
    logic [25:0] cfg_h_prod;
    logic [9:0]  cfg_bands_raw;

    logic                     in_accept;
    logic                     load_ok;
    logic                     load_col_last;
    logic [AW-1:0]            wr_addr;
    logic [WORD_BITS-1:0]     wr_data;
    logic [ROWS_PER_BAND-1:0] wr_lane;
    logic [BW-1:0]            rd_band_addr;
    logic [CW-1:0]            rd_col;
    logic [AW-1:0]            rd_addr;
    logic [15:0]              pels;
    logic                     expand;
    logic [BW-1:0]            band_inc;
    t_mask_ctl                mask_ctl;
    logic [ROWS_PER_BAND-1:0] mask_column;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;
    assign o_no_data   = r_out_nodata;

    // derived geometry, computed from the write data so it is current at the write edge
    assign cfg_w_sum     = 11'(i_cfg_data[9:0]) + 11'd7;
    assign cfg_bytes_raw = cfg_w_sum[10:3];
    assign cfg_h_sum     = 12'(i_cfg_data[10:0]) + 12'd6;
    assign cfg_h_prod    = 26'(cfg_h_sum) * 26'(BANDS_RECIP);
    assign cfg_bands_raw = cfg_h_prod[RECIP_SHIFT +: 10];

    always_comb begin
        if (int'(cfg_bytes_raw) > MAX_WIDTH_BYTES) begin
            n_width_bytes = YW'(MAX_WIDTH_BYTES);
        end else begin
            n_width_bytes = YW'(cfg_bytes_raw);
        end
        if (int'(cfg_bands_raw) > MAX_BANDS) begin
            n_bands = BW'(MAX_BANDS);
        end else begin
            n_bands = BW'(cfg_bands_raw);
        end
    end

    // load path
    assign load_ok = (r_width_bytes != '0) && (r_load_band < r_bands) &&
                     (YW'(r_load_col) < r_width_bytes);
    assign load_col_last = (YW'(r_load_col) + YW'(1)) >= r_width_bytes;
    assign wr_addr = AW'(r_load_band) * AW'(MAX_WIDTH_BYTES) + AW'(r_load_col);

    // row 0 opens the word and drops whatever the other rows held
    always_comb begin
        if (r_load_row == 3'd0) begin
            wr_data = WORD_BITS'(i_raster_byte);
            wr_lane = '1;
        end else begin
            wr_data = {ROWS_PER_BAND{i_raster_byte}};
            wr_lane = ROWS_PER_BAND'(1) << r_load_row;
        end
    end

    // stream walk
    assign pels     = 16'(r_width_bytes) << 3;
    assign expand   = pels[7];
    assign band_inc = r_band + BW'(1);

    assign rd_band_addr = r_bands - BW'(1) - r_band;
    assign rd_col       = r_index[3 +: CW];
    assign rd_addr      = AW'(rd_band_addr) * AW'(MAX_WIDTH_BYTES) + AW'(rd_col);

    always_comb begin
        n_phase      = r_phase;
        n_index      = r_index;
        n_band       = r_band;
        n_res_byte   = 8'd0;
        n_res_last   = 1'b0;
        n_res_nodata = 1'b0;
        step_emit    = 1'b0;
        step_read    = 1'b0;
        case (r_phase)
            PH_INIT: begin
                if (r_index < IW'(INIT_LEN)) begin
                    n_res_byte = init_byte(r_index[2:0]);
                    step_emit  = 1'b1;
                end else begin
                    n_phase = (r_band < r_bands) ? PH_HEADER : PH_FINAL;
                    n_index = '0;
                end
            end
            PH_HEADER: begin
                if (r_index < IW'(HEADER_LEN)) begin
                    step_emit = 1'b1;
                    case (r_index[2:0])
                        3'd0:    n_res_byte = CHR_ESC;
                        3'd1:    n_res_byte = CHR_STAR;
                        3'd2:    n_res_byte = GFX_MODE;
                        3'd3:    n_res_byte = expand ? {1'b0, pels[6:0]} : pels[7:0];
                        default: n_res_byte = pels[15:8] + 8'(expand);
                    endcase
                end else begin
                    n_phase = PH_COLUMNS;
                    n_index = '0;
                end
            end
            PH_COLUMNS: begin
                if ((16'(r_index) < pels) && (r_band < r_bands)) begin
                    step_read = 1'b1;
                end else begin
                    n_phase = PH_PAD;
                    n_index = '0;
                end
            end
            PH_PAD: begin
                if (expand && (r_index < IW'(EXPAND_COLUMNS))) begin
                    step_emit = 1'b1;
                end else begin
                    n_phase = PH_NEWLINE;
                    n_index = '0;
                end
            end
            PH_NEWLINE: begin
                if (r_index == '0) begin
                    n_res_byte = CHR_NL;
                    step_emit  = 1'b1;
                end else begin
                    n_band  = band_inc;
                    n_phase = (band_inc < r_bands) ? PH_HEADER : PH_FINAL;
                    n_index = '0;
                end
            end
            PH_FINAL: begin
                if (r_index < IW'(FINAL_LEN)) begin
                    n_res_byte = r_index[0] ? CHR_AT : CHR_ESC;
                    n_res_last = r_index[0];
                    step_emit  = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                    n_index = '0;
                end
            end
            default: begin
                n_phase      = PH_DONE;
                n_res_nodata = 1'b1;
                step_emit    = 1'b1;
            end
        endcase
    end

    assign mask_ctl.band_done    = r_rd_band < r_load_band;
    assign mask_ctl.band_current = r_rd_band == r_load_band;
    assign mask_ctl.col_done     = r_rd_col < r_load_col;
    assign mask_ctl.row          = r_load_row;

    pbct_col_mask u_col_mask (
        .i_word    (r_rdata),
        .i_bit_sel (r_rd_bit),
        .i_ctl     (mask_ctl),
        .o_column  (mask_column)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_cmd == CMD_LOAD) && load_ok) begin
            for (int k = 0; k < ROWS_PER_BAND; k++) begin
                if (wr_lane[k]) begin
                    mem[wr_addr][8 * k +: 8] <= wr_data[8 * k +: 8];
                end
            end
        end
        if ((r_state == ST_WALK) && step_read) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_width_bytes <= YW'(RESET_BYTES);
            r_bands       <= BW'(RESET_BANDS);
            r_load_band   <= '0;
            r_load_row    <= 3'd0;
            r_load_col    <= '0;
            r_phase       <= PH_INIT;
            r_band        <= '0;
            r_index       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width_bytes <= n_width_bytes;
                    CFG_HEIGHT: r_bands       <= n_bands;
                    default:    ;
                endcase
            end
            if ((r_state == ST_SEND) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        case (i_cmd)
                            CMD_LOAD: begin
                                if (load_ok) begin
                                    if (load_col_last) begin
                                        r_load_col <= '0;
                                        if (r_load_row == 3'(ROWS_PER_BAND - 1)) begin
                                            r_load_row  <= 3'd0;
                                            r_load_band <= r_load_band + BW'(1);
                                        end else begin
                                            r_load_row <= r_load_row + 3'd1;
                                        end
                                    end else begin
                                        r_load_col <= r_load_col + CW'(1);
                                    end
                                end
                            end
                            CMD_FETCH: r_state <= ST_WALK;
                            CMD_RESTART: begin
                                r_load_band <= '0;
                                r_load_row  <= 3'd0;
                                r_load_col  <= '0;
                                r_phase     <= PH_INIT;
                                r_band      <= '0;
                                r_index     <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    r_phase <= n_phase;
                    r_band  <= n_band;
                    if (step_emit && !n_res_nodata) begin
                        r_index <= r_index + IW'(1);
                    end else begin
                        r_index <= n_index;
                    end
                    if (step_read) begin
                        r_state <= ST_MASK;
                    end else if (step_emit) begin
                        r_state <= ST_SEND;
                    end
                end
                ST_MASK: begin
                    r_index <= r_index + IW'(1);
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WALK) && step_read) begin
            r_rd_band <= rd_band_addr;
            r_rd_col  <= rd_col;
            r_rd_bit  <= r_index[2:0];
        end
        if ((r_state == ST_WALK) && step_emit && !step_read) begin
            r_res_byte   <= n_res_byte;
            r_res_last   <= n_res_last;
            r_res_nodata <= n_res_nodata;
        end else if (r_state == ST_MASK) begin
            r_res_byte   <= {1'b0, mask_column};
            r_res_last   <= 1'b0;
            r_res_nodata <= 1'b0;
        end
        if ((r_state == ST_SEND) && (!r_out_valid || i_out_ready)) begin
            r_out_byte   <= r_res_byte;
            r_out_last   <= r_res_last;
            r_out_nodata <= r_res_nodata;
        end
    end

endmodule

@@ design/pbct_col_mask.sv @@
`timescale 1ns / 1ps

module pbct_col_mask (
    input  logic [pbct_pkg::WORD_BITS-1:0]     i_word,
    input  logic [2:0]                         i_bit_sel,
    input  pbct_pkg::t_mask_ctl                i_ctl,
    output logic [pbct_pkg::ROWS_PER_BAND-1:0] o_column
);
    import pbct_pkg::*;

    logic [2:0]               bit_pos;
    logic [ROWS_PER_BAND-1:0] row_loaded;

    // leftmost pixel sits in bit 7 of each row byte
    assign bit_pos = 3'd7 - i_bit_sel;

    always_comb begin
        for (int r = 0; r < ROWS_PER_BAND; r++) begin
            row_loaded[r] = i_ctl.band_done ||
                            (i_ctl.band_current &&
                             ((3'(r) < i_ctl.row) || ((3'(r) == i_ctl.row) && i_ctl.col_done)));
        end
    end

    always_comb begin
        for (int r = 0; r < ROWS_PER_BAND; r++) begin
            o_column[r] = row_loaded[r] && i_word[8 * r + int'(bit_pos)];
        end
    end

endmodule

@@ design/pbct_checker.sv @@
`timescale 1ns / 1ps

module pbct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_cmd,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_byte,
    input logic       o_no_data
);
    import pbct_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_last_byte) && $stable(o_no_data))
        else $error("result changed while stalled");

    a_no_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_data |-> (o_out_byte == 8'd0) && !o_last_byte)
        else $error("no_data result carries payload");

    a_last_is_at: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> (o_out_byte == CHR_AT) && !o_no_data)
        else $error("last byte is not the closing reset byte");

    // loads and restarts never raise a result
    a_quiet_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd != CMD_FETCH) && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without a fetch");

    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_FETCH) |=> !o_in_ready)
        else $error("new transfer taken while a fetch is in progress");

endmodule

bind printer_band_column_transpose pbct_checker u_pbct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_last_byte (o_last_byte),
    .o_no_data   (o_no_data)
);
